FILE: design/gradient_color_stop_interpolator_core_macros.svh
// Assertion macros for the gradient color stop interpolator.
// Used by the top level; expects clk and rst_n in scope.
`ifndef GRADIENT_COLOR_STOP_INTERPOLATOR_CORE_MACROS_SVH
`define GRADIENT_COLOR_STOP_INTERPOLATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define GCSI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcsi assertion failed");
`define GCSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcsi assertion failed");
`else
`define GCSI_ASSERT_IMPL(label, ante, cons)
`define GCSI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: design/gcsi_pkg.sv
// Shared constants and types for the gradient color stop interpolator.
// No dependencies.
package gcsi_pkg;

    localparam int MAX_STOPS = 4;
    localparam int STOP_REGS = 4;
    localparam int NSTOP     = (MAX_STOPS < STOP_REGS) ? MAX_STOPS : STOP_REGS;
    localparam int RANK_W    = (NSTOP > 1) ? $clog2(NSTOP) : 1;
    localparam int CNT_W     = 3;
    localparam int POS_W     = 17;
    localparam int COLOR_W   = 32;
    localparam int STOP_W    = 49;
    localparam int SCALE_W   = 9;
    localparam int FRAC_BITS = 16;
    localparam int T_W       = FRAC_BITS + 1;
    localparam int DIV_STEPS = FRAC_BITS;

    localparam logic [POS_W-1:0]   ONE_Q16     = 17'd65536;
    localparam logic [COLOR_W-1:0] WHITE_COLOR = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [2:0] CFG_STOP_COUNT = 3'd0;
    localparam logic [2:0] CFG_STOP_BASE  = 3'd1;

    // payload riding alongside the divider
    typedef struct packed {
        logic [COLOR_W-1:0] cl;
        logic [COLOR_W-1:0] cr;
        logic [SCALE_W-1:0] scale;
    } side_t;

endpackage

FILE: design/gcsi_div_pipe.sv
// Pipelined restoring divider: t = floor(x * 2^16 / d) for x <= d, one bit per stage.
// Depends on gcsi_pkg.
module gcsi_div_pipe
    import gcsi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [POS_W-1:0] x,
    input  logic [POS_W-1:0] d,
    input  logic             dz,
    input  side_t            in_side,
    output logic             out_valid,
    output logic [T_W-1:0]   t,
    output side_t            out_side
);

    logic [DIV_STEPS-1:0] valid_reg;
    logic [POS_W-1:0]     rem_reg  [DIV_STEPS];
    logic [T_W-1:0]       q_reg    [DIV_STEPS];
    logic [POS_W-1:0]     d_reg    [DIV_STEPS];
    logic                 dz_reg   [DIV_STEPS];
    side_t                side_reg [DIV_STEPS];

    logic [POS_W-1:0] rem_init;
    logic             q_int;

    // integer quotient bit is 1 only when x equals d
    assign q_int    = (x == d);
    assign rem_init = q_int ? '0 : x;

    genvar g;
    generate
        for (g = 0; g < DIV_STEPS; g++) begin : g_step
            logic [POS_W-1:0] rem_prev;
            logic [T_W-1:0]   q_prev;
            logic [POS_W-1:0] d_prev;
            logic             dz_prev;
            side_t            side_prev;
            logic             valid_prev;
            logic [POS_W:0]   rem_sh;
            logic             take;
            logic [POS_W-1:0] rem_next;
            logic [T_W-1:0]   q_next;

            if (g == 0) begin : g_first
                assign rem_prev   = rem_init;
                assign q_prev     = {q_int, {FRAC_BITS{1'b0}}};
                assign d_prev     = d;
                assign dz_prev    = dz;
                assign side_prev  = in_side;
                assign valid_prev = in_valid;
            end else begin : g_rest
                assign rem_prev   = rem_reg[g-1];
                assign q_prev     = q_reg[g-1];
                assign d_prev     = d_reg[g-1];
                assign dz_prev    = dz_reg[g-1];
                assign side_prev  = side_reg[g-1];
                assign valid_prev = valid_reg[g-1];
            end

            assign rem_sh   = {rem_prev, 1'b0};
            assign take     = (rem_sh >= {1'b0, d_prev});
            assign rem_next = take ? POS_W'(rem_sh - {1'b0, d_prev}) : rem_sh[POS_W-1:0];

            always_comb
            begin
                q_next = q_prev;
                q_next[FRAC_BITS-1-g] = take;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[g] <= 1'b0;
                end
                else if (en)
                begin
                    valid_reg[g] <= valid_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g]  <= rem_next;
                    q_reg[g]    <= q_next;
                    d_reg[g]    <= d_prev;
                    dz_reg[g]   <= dz_prev;
                    side_reg[g] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[DIV_STEPS-1];
    // zero-width segment uses t = 0
    assign t         = dz_reg[DIV_STEPS-1] ? '0 : q_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

endmodule

FILE: design/gradient_color_stop_interpolator_core.sv
// Multi-stop linear color gradient: position and alpha scale in, RGBA out.
// 20 register stages from input transfer to the output register; throughput one item per cycle
// when not stalled. Most of the stages belong to the 16-stage bit-per-stage divider.
// The whole pipeline stalls together while the output register waits for m_axis_tready.
// Reset (rst_n, async, active low) clears valid bits, stop count and stop registers.
module gradient_color_stop_interpolator_core
    import gcsi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [17:0] target_position, [26:18] alpha_scale
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [48:0] cfg_wdata
);

`include "gradient_color_stop_interpolator_core_macros.svh"

    logic en;

    // configuration
    logic [2:0]        stop_count_reg;
    logic [STOP_W-1:0] stop_reg [STOP_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_count_reg <= '0;
            for (int i = 0; i < STOP_REGS; i++)
            begin
                stop_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_STOP_COUNT)
            begin
                stop_count_reg <= cfg_wdata[2:0];
            end
            for (int i = 0; i < STOP_REGS; i++)
            begin
                if (cfg_index == 3'(i + int'(CFG_STOP_BASE)))
                begin
                    stop_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    logic [CNT_W-1:0]  n_eff;
    logic [POS_W-1:0]  pos   [NSTOP];
    logic [RANK_W-1:0] rank  [NSTOP];

    assign n_eff = (stop_count_reg > CNT_W'(NSTOP)) ? CNT_W'(NSTOP) : stop_count_reg;

    // stable rank of each active stop
    always_comb
    begin
        for (int i = 0; i < NSTOP; i++)
        begin
            pos[i] = stop_reg[i][STOP_W-1:COLOR_W];
        end
        for (int i = 0; i < NSTOP; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < NSTOP; j++)
            begin
                if (CNT_W'(j) < n_eff)
                begin
                    if ((j < i && pos[j] <= pos[i]) || (j > i && pos[j] < pos[i]))
                    begin
                        rank[i] = rank[i] + RANK_W'(1);
                    end
                end
            end
        end
    end

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: clamp and compare against stop positions
    logic               s1_valid_reg;
    logic [POS_W-1:0]   s1_p_reg;
    logic [SCALE_W-1:0] s1_scale_reg;
    logic [NSTOP-1:0]   s1_lt_reg;
    logic [NSTOP-1:0]   s1_le_reg;

    logic [17:0]      in_pos;
    logic [POS_W-1:0] p_clamp;
    logic [NSTOP-1:0] lt_next;
    logic [NSTOP-1:0] le_next;

    always_comb
    begin
        in_pos = s_axis_tdata[17:0];
        if (in_pos[17])
        begin
            p_clamp = '0;
        end
        else if (in_pos[16:0] > ONE_Q16)
        begin
            p_clamp = ONE_Q16;
        end
        else
        begin
            p_clamp = in_pos[16:0];
        end
        for (int i = 0; i < NSTOP; i++)
        begin
            lt_next[i] = pos[i] < p_clamp;
            le_next[i] = pos[i] <= p_clamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_p_reg     <= p_clamp;
            s1_scale_reg <= s_axis_tdata[26:18];
            s1_lt_reg    <= lt_next;
            s1_le_reg    <= le_next;
        end
    end

    // stage 2: pick segment, form numerator and span
    logic              s2_valid_reg;
    logic [POS_W-1:0]  s2_x_reg;
    logic [POS_W-1:0]  s2_d_reg;
    logic              s2_dz_reg;
    side_t             s2_side_reg;

    logic [CNT_W-1:0]  cnt_lt;
    logic [CNT_W-1:0]  cnt_le;
    logic [CNT_W-1:0]  sel_l_cnt;
    logic [CNT_W-1:0]  sel_r_cnt;
    logic              end_mode;
    logic [STOP_W-1:0] stop_l;
    logic [STOP_W-1:0] stop_r;
    logic [POS_W-1:0]  x_next;
    logic [POS_W-1:0]  d_next;
    logic              dz_next;
    side_t             side_next;

    always_comb
    begin
        cnt_lt = '0;
        cnt_le = '0;
        for (int i = 0; i < NSTOP; i++)
        begin
            if (CNT_W'(i) < n_eff)
            begin
                cnt_lt = cnt_lt + CNT_W'(s1_lt_reg[i]);
                cnt_le = cnt_le + CNT_W'(s1_le_reg[i]);
            end
        end

        end_mode  = 1'b1;
        sel_l_cnt = '0;
        sel_r_cnt = '0;
        if (cnt_lt == '0)
        begin
            sel_l_cnt = '0;
        end
        else if (cnt_le == n_eff)
        begin
            sel_l_cnt = n_eff - CNT_W'(1);
        end
        else
        begin
            end_mode  = 1'b0;
            sel_l_cnt = cnt_lt - CNT_W'(1);
            sel_r_cnt = cnt_lt;
        end

        // one stop: stop_0 regardless of position (rank 0 anyway)
        stop_l = stop_reg[0];
        stop_r = stop_reg[0];
        for (int i = 0; i < NSTOP; i++)
        begin
            if (CNT_W'(i) < n_eff && CNT_W'(rank[i]) == sel_l_cnt)
            begin
                stop_l = stop_reg[i];
            end
            if (CNT_W'(i) < n_eff && CNT_W'(rank[i]) == sel_r_cnt)
            begin
                stop_r = stop_reg[i];
            end
        end

        side_next.scale = s1_scale_reg;
        if (n_eff == '0)
        begin
            side_next.cl = WHITE_COLOR;
            side_next.cr = WHITE_COLOR;
            x_next       = '0;
            d_next       = '0;
            dz_next      = 1'b1;
        end
        else if (end_mode || n_eff == CNT_W'(1))
        begin
            side_next.cl = stop_l[COLOR_W-1:0];
            side_next.cr = stop_l[COLOR_W-1:0];
            x_next       = '0;
            d_next       = '0;
            dz_next      = 1'b1;
        end
        else
        begin
            side_next.cl = stop_l[COLOR_W-1:0];
            side_next.cr = stop_r[COLOR_W-1:0];
            x_next       = s1_p_reg - stop_l[STOP_W-1:COLOR_W];
            d_next       = stop_r[STOP_W-1:COLOR_W] - stop_l[STOP_W-1:COLOR_W];
            dz_next      = (d_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_x_reg    <= x_next;
            s2_d_reg    <= d_next;
            s2_dz_reg   <= dz_next;
            s2_side_reg <= side_next;
        end
    end

    // divider stages
    logic           dv_valid;
    logic [T_W-1:0] dv_t;
    side_t          dv_side;

    gcsi_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .x         (s2_x_reg),
        .d         (s2_d_reg),
        .dz        (s2_dz_reg),
        .in_side   (s2_side_reg),
        .out_valid (dv_valid),
        .t         (dv_t),
        .out_side  (dv_side)
    );

    // lerp stage: c = floor((cl * 2^16 + t * (cr - cl)) / 2^16)
    logic               lp_valid_reg;
    logic [7:0]         lp_ch_reg [4];
    logic [SCALE_W-1:0] lp_scale_reg;
    logic [7:0]         ch_next   [4];

    always_comb
    begin
        logic [7:0]         cl_c;
        logic [7:0]         cr_c;
        logic signed [8:0]  diff;
        logic signed [26:0] prod;
        logic signed [26:0] sum;
        for (int k = 0; k < 4; k++)
        begin
            cl_c       = dv_side.cl[8*k +: 8];
            cr_c       = dv_side.cr[8*k +: 8];
            diff       = $signed({1'b0, cr_c}) - $signed({1'b0, cl_c});
            prod       = $signed({1'b0, dv_t}) * diff;
            sum        = $signed({3'b000, cl_c, 16'h0000}) + prod;
            ch_next[k] = sum[23:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            lp_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                lp_ch_reg[k] <= ch_next[k];
            end
            lp_scale_reg <= dv_side.scale;
        end
    end

    // output stage: alpha scaling, saturate at 255
    // color byte k: 0 = alpha, 1 = blue, 2 = green, 3 = red
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [16:0] alpha_prod;
    logic [7:0]  alpha_next;

    assign alpha_prod = lp_ch_reg[0] * lp_scale_reg;
    assign alpha_next = alpha_prod[16] ? 8'hFF : alpha_prod[15:8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= lp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {alpha_next, lp_ch_reg[1], lp_ch_reg[2], lp_ch_reg[3]};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `GCSI_ASSERT_IMPL(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    `GCSI_ASSERT_IMPL(a_t_in_range, dv_valid, dv_t <= ONE_Q16)
    `GCSI_ASSERT_IMPL(a_zero_span_zero_num, s2_valid_reg && s2_dz_reg, s2_x_reg == '0)
    `GCSI_ASSERT_NEXT(a_lerp_to_out, en && lp_valid_reg, m_axis_tvalid)

endmodule
